// ===== rtl/dism_pkg.sv =====
// Shared constants, result codes and table command type for the interval set block.
// No dependencies; used by the interfaces, the table and the top level.
`default_nettype none
package dism_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KIND_W   = 3;
	localparam int OP_W     = 3;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_COVERED = 3'd0;
	localparam logic [KIND_W-1:0] KIND_NEW     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LEFT    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RIGHT   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_JOINED  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_FULL    = 3'd5;
	localparam logic [KIND_W-1:0] KIND_ENTRY   = 3'd6;
	localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd7;

	// Table update operations
	localparam logic [OP_W-1:0] OP_NONE      = 3'd0;
	localparam logic [OP_W-1:0] OP_SET_END   = 3'd1;
	localparam logic [OP_W-1:0] OP_SET_START = 3'd2;
	localparam logic [OP_W-1:0] OP_JOIN      = 3'd3;
	localparam logic [OP_W-1:0] OP_INSERT    = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] value;
	} tbl_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/dism_in_if.sv =====
// Input channel: action and value with valid/ready handshake.
// Depends on dism_pkg for the value width.
`default_nettype none
interface dism_in_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [dism_pkg::DATA_W-1:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface
`default_nettype wire

// ===== rtl/dism_out_if.sv =====
// Result channel: kind, interval bounds, entry count and last flag with valid/ready.
// Depends on dism_pkg for field widths.
`default_nettype none
interface dism_out_if;
	logic                        valid;
	logic                        ready;
	logic [dism_pkg::KIND_W-1:0] kind;
	logic [dism_pkg::DATA_W-1:0] range_start;
	logic [dism_pkg::DATA_W-1:0] range_end;
	logic [dism_pkg::CNT_W-1:0]  entry_count;
	logic                        last;

	modport source (output valid, output kind, output range_start, output range_end,
		output entry_count, output last, input ready);
	modport sink (input valid, input kind, input range_start, input range_end,
		input entry_count, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/dism_table.sv =====
// Interval table storage: one read port and registered set, join-shift and insert-shift.
// Depends on dism_pkg for widths, operation codes and the command struct.
`default_nettype none
module dism_table (
	input  wire logic                        clk,
	input  wire dism_pkg::tbl_cmd_t          cmd,
	input  wire logic [dism_pkg::IDX_W-1:0]  rd_idx,
	output logic      [dism_pkg::DATA_W-1:0] rd_start,
	output logic      [dism_pkg::DATA_W-1:0] rd_end
);

	logic [dism_pkg::DATA_W-1:0] start_q [dism_pkg::CAPACITY];
	logic [dism_pkg::DATA_W-1:0] end_q   [dism_pkg::CAPACITY];
	logic [dism_pkg::DATA_W-1:0] up_start [dism_pkg::CAPACITY];
	logic [dism_pkg::DATA_W-1:0] up_end   [dism_pkg::CAPACITY];
	logic [dism_pkg::DATA_W-1:0] dn_start [dism_pkg::CAPACITY];
	logic [dism_pkg::DATA_W-1:0] dn_end   [dism_pkg::CAPACITY];

	assign rd_start = start_q[rd_idx];
	assign rd_end   = end_q[rd_idx];

	for (genvar gi = 0; gi < dism_pkg::CAPACITY; gi++) begin : g_entry
		// neighbor taps for the shift paths
		if (gi < dism_pkg::CAPACITY - 1) begin : g_up
			assign up_start[gi] = start_q[gi + 1];
			assign up_end[gi]   = end_q[gi + 1];
		end else begin : g_up_top
			assign up_start[gi] = start_q[gi];
			assign up_end[gi]   = end_q[gi];
		end
		if (gi > 0) begin : g_dn
			assign dn_start[gi] = start_q[gi - 1];
			assign dn_end[gi]   = end_q[gi - 1];
		end else begin : g_dn_bot
			assign dn_start[gi] = start_q[gi];
			assign dn_end[gi]   = end_q[gi];
		end

		always_ff @(posedge clk) begin
			unique case (cmd.op)
				dism_pkg::OP_SET_END: begin
					if (cmd.idx == dism_pkg::IDX_W'(gi)) end_q[gi] <= cmd.value;
				end
				dism_pkg::OP_SET_START: begin
					if (cmd.idx == dism_pkg::IDX_W'(gi)) start_q[gi] <= cmd.value;
				end
				dism_pkg::OP_JOIN: begin
					// left neighbor takes the right end, the rest closes up by one
					if (dism_pkg::CNT_W'(gi + 1) == dism_pkg::CNT_W'(cmd.idx)) begin
						end_q[gi] <= cmd.value;
					end else if (dism_pkg::CNT_W'(gi) >= dism_pkg::CNT_W'(cmd.idx)) begin
						start_q[gi] <= up_start[gi];
						end_q[gi]   <= up_end[gi];
					end
				end
				dism_pkg::OP_INSERT: begin
					// open a slot at idx, entries above move up by one
					if (cmd.idx == dism_pkg::IDX_W'(gi)) begin
						start_q[gi] <= cmd.value;
						end_q[gi]   <= cmd.value;
					end else if (dism_pkg::CNT_W'(gi) > dism_pkg::CNT_W'(cmd.idx)) begin
						start_q[gi] <= dn_start[gi];
						end_q[gi]   <= dn_end[gi];
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/disjoint_interval_set_merge_core.sv =====
// Top level of the disjoint interval set: sequencer, shared compare and result register.
// Depends on dism_pkg, dism_in_if, dism_out_if and dism_table.
//
//   channel | dir | handshake   | payload
//   req     | in  | valid/ready | action, value
//   rsp     | out | valid/ready | kind, range_start, range_end, entry_count, last
//
// An add walks the table in order with one start compare per cycle, advancing past the p
// held intervals whose start is at most value; the decide state then waits for a free
// result slot and applies the merge or the shift. A list gives n results for n held
// intervals (one empty result for an empty table), one table read per result.
// Reset clears the interval count; table contents are don't-care until written.
// A stalled rsp holds the result register; req is taken again once the sequencer idles.
`default_nettype none
module disjoint_interval_set_merge_core (
	input  wire logic clk,
	input  wire logic arst_n,
	dism_in_if.sink   req,
	dism_out_if.source rsp
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;
	localparam logic [1:0] ST_LIST   = 2'd3;

	logic [1:0]                  state_q;
	logic [dism_pkg::DATA_W-1:0] v_q;
	logic [dism_pkg::CNT_W-1:0]  p_q;
	logic [dism_pkg::CNT_W-1:0]  n_q;
	logic [dism_pkg::CNT_W-1:0]  list_i_q;
	logic [dism_pkg::DATA_W-1:0] left_start_q;
	logic [dism_pkg::DATA_W-1:0] left_end_q;

	logic                        out_valid_q;
	logic [dism_pkg::KIND_W-1:0] out_kind_q;
	logic [dism_pkg::DATA_W-1:0] out_start_q;
	logic [dism_pkg::DATA_W-1:0] out_end_q;
	logic [dism_pkg::CNT_W-1:0]  out_count_q;
	logic                        out_last_q;

	dism_pkg::tbl_cmd_t          cmd;
	logic [dism_pkg::IDX_W-1:0]  rd_idx;
	logic [dism_pkg::DATA_W-1:0] rd_start;
	logic [dism_pkg::DATA_W-1:0] rd_end;

	logic slot_free;
	logic emit;
	logic accept;
	logic start_le_v;
	logic has_left;
	logic has_right;
	logic covered;
	logic touch_left;
	logic touch_right;
	logic is_full;
	logic list_last;

	dism_table u_table (
		.clk      (clk),
		.cmd      (cmd),
		.rd_idx   (rd_idx),
		.rd_start (rd_start),
		.rd_end   (rd_end)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;
	assign emit      = slot_free && (state_q == ST_DECIDE || state_q == ST_LIST);

	assign rd_idx = (state_q == ST_LIST) ? list_i_q[dism_pkg::IDX_W-1:0]
	                                     : p_q[dism_pkg::IDX_W-1:0];

	// shared compare used by the walk
	assign start_le_v = (rd_start <= v_q);

	assign has_left    = (p_q != '0);
	assign has_right   = (p_q < n_q);
	assign covered     = has_left && (left_end_q >= v_q);
	assign touch_left  = has_left &&
		(({1'b0, left_end_q} + 17'd1) == {1'b0, v_q});
	assign touch_right = has_right &&
		(({1'b0, v_q} + 17'd1) == {1'b0, rd_start});
	assign is_full     = (n_q == dism_pkg::CNT_W'(dism_pkg::CAPACITY));
	assign list_last   = ((list_i_q + dism_pkg::CNT_W'(1)) == n_q);

	always_comb begin
		cmd       = '0;
		cmd.op    = dism_pkg::OP_NONE;
		cmd.idx   = p_q[dism_pkg::IDX_W-1:0];
		cmd.value = v_q;
		if (state_q == ST_DECIDE && slot_free && !covered) begin
			if (touch_left && touch_right) begin
				cmd.op    = dism_pkg::OP_JOIN;
				cmd.value = rd_end;
			end else if (touch_left) begin
				cmd.op  = dism_pkg::OP_SET_END;
				cmd.idx = dism_pkg::IDX_W'(p_q - dism_pkg::CNT_W'(1));
			end else if (touch_right) begin
				cmd.op = dism_pkg::OP_SET_START;
			end else if (!is_full) begin
				cmd.op = dism_pkg::OP_INSERT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			p_q         <= '0;
			list_i_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						p_q      <= '0;
						list_i_q <= '0;
						state_q  <= req.action ? ST_LIST : ST_SCAN;
					end
				end
				ST_SCAN: begin
					// advance past every start at or below value, remember the left one
					if (has_right && start_le_v) begin
						p_q <= p_q + dism_pkg::CNT_W'(1);
					end else begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
						if (!covered && touch_left && touch_right) begin
							n_q <= n_q - dism_pkg::CNT_W'(1);
						end else if (!covered && !touch_left && !touch_right && !is_full) begin
							n_q <= n_q + dism_pkg::CNT_W'(1);
						end
					end
				end
				ST_LIST: begin
					if (slot_free) begin
						list_i_q <= list_i_q + dism_pkg::CNT_W'(1);
						if (n_q == '0 || list_last) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) v_q <= req.value;
		if (state_q == ST_SCAN && has_right && start_le_v) begin
			left_start_q <= rd_start;
			left_end_q   <= rd_end;
		end
		if (state_q == ST_DECIDE && slot_free) begin
			out_last_q <= 1'b1;
			if (covered) begin
				out_kind_q  <= dism_pkg::KIND_COVERED;
				out_start_q <= left_start_q;
				out_end_q   <= left_end_q;
				out_count_q <= n_q;
			end else if (touch_left && touch_right) begin
				out_kind_q  <= dism_pkg::KIND_JOINED;
				out_start_q <= left_start_q;
				out_end_q   <= rd_end;
				out_count_q <= n_q - dism_pkg::CNT_W'(1);
			end else if (touch_left) begin
				out_kind_q  <= dism_pkg::KIND_LEFT;
				out_start_q <= left_start_q;
				out_end_q   <= v_q;
				out_count_q <= n_q;
			end else if (touch_right) begin
				out_kind_q  <= dism_pkg::KIND_RIGHT;
				out_start_q <= v_q;
				out_end_q   <= rd_end;
				out_count_q <= n_q;
			end else if (is_full) begin
				out_kind_q  <= dism_pkg::KIND_FULL;
				out_start_q <= v_q;
				out_end_q   <= v_q;
				out_count_q <= n_q;
			end else begin
				out_kind_q  <= dism_pkg::KIND_NEW;
				out_start_q <= v_q;
				out_end_q   <= v_q;
				out_count_q <= n_q + dism_pkg::CNT_W'(1);
			end
		end else if (state_q == ST_LIST && slot_free) begin
			out_count_q <= n_q;
			if (n_q == '0) begin
				out_kind_q  <= dism_pkg::KIND_EMPTY;
				out_start_q <= '0;
				out_end_q   <= '0;
				out_last_q  <= 1'b1;
			end else begin
				out_kind_q  <= dism_pkg::KIND_ENTRY;
				out_start_q <= rd_start;
				out_end_q   <= rd_end;
				out_last_q  <= list_last;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.kind        = out_kind_q;
	assign rsp.range_start = out_start_q;
	assign rsp.range_end   = out_end_q;
	assign rsp.entry_count = out_count_q;
	assign rsp.last        = out_last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= dism_pkg::CNT_W'(dism_pkg::CAPACITY))
		else $error("interval count above capacity");

	a_list_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LIST && n_q != '0) |-> (list_i_q < n_q))
		else $error("list index past held entries");

	a_full_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.kind == dism_pkg::KIND_FULL) |->
		(rsp.entry_count == dism_pkg::CNT_W'(dism_pkg::CAPACITY)))
		else $error("drop reported on a table with room");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_DECIDE) |-> (p_q <= n_q))
		else $error("walk pointer past held entries");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_disjoint_interval_set_merge_core.sv =====
// Self-checking bench for disjoint_interval_set_merge_core: directed edge cases, a full
// table, random add/list traffic and long output back-pressure, checked against a mirror.
// Depends on dism_pkg, dism_in_if, dism_out_if and the core RTL.
`default_nettype none
module tb_disjoint_interval_set_merge_core;

	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_LIST = 1'b1;
	localparam int   SETTLE_CYCLES = 40;

	typedef struct {
		logic [dism_pkg::KIND_W-1:0] kind;
		logic [dism_pkg::DATA_W-1:0] lo;
		logic [dism_pkg::DATA_W-1:0] hi;
		logic [dism_pkg::CNT_W-1:0]  count;
		logic                        last;
	} span_result_t;

	logic clk = 1'b0;
	logic arst_n;

	dism_in_if  req();
	dism_out_if rsp();

	disjoint_interval_set_merge_core u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	always #5 clk = ~clk;

	// Mirror of the interval table, kept in step with every accepted add request.
	logic [dism_pkg::DATA_W-1:0] span_lo [dism_pkg::CAPACITY];
	logic [dism_pkg::DATA_W-1:0] span_hi [dism_pkg::CAPACITY];
	int                span_cnt = 0;
	span_result_t      pending_spans[$];

	int fail_cnt     = 0;
	int hold_request = 0;
	bit tx_gap_en    = 1'b0;
	bit rx_stall_en  = 1'b0;

	function automatic void push_span(input logic [dism_pkg::KIND_W-1:0] kind,
		input logic [dism_pkg::DATA_W-1:0] lo, input logic [dism_pkg::DATA_W-1:0] hi,
		input logic last);
		span_result_t r;
		r.kind  = kind;
		r.lo    = lo;
		r.hi    = hi;
		r.count = dism_pkg::CNT_W'(span_cnt);
		r.last  = last;
		pending_spans.insert(pending_spans.size(), r);
	endfunction

	function automatic void apply_add(input logic [dism_pkg::DATA_W-1:0] val);
		int pos;
		int vi;
		bit touch_l;
		bit touch_r;
		vi  = int'(val);
		pos = 0;
		while (pos < span_cnt && int'(span_lo[pos]) <= vi)
			pos++;
		if (pos > 0 && int'(span_hi[pos-1]) >= vi) begin
			push_span(dism_pkg::KIND_COVERED, span_lo[pos-1], span_hi[pos-1], 1'b1);
			return;
		end
		// compare in int so that the top value never wraps onto zero
		touch_l = pos > 0 && int'(span_hi[pos-1]) + 1 == vi;
		touch_r = pos < span_cnt && int'(span_lo[pos]) == vi + 1;
		if (touch_l && touch_r) begin
			span_hi[pos-1] = span_hi[pos];
			for (int i = pos; i + 1 < span_cnt; i++) begin
				span_lo[i] = span_lo[i+1];
				span_hi[i] = span_hi[i+1];
			end
			span_cnt--;
			push_span(dism_pkg::KIND_JOINED, span_lo[pos-1], span_hi[pos-1], 1'b1);
		end else if (touch_l) begin
			span_hi[pos-1] = val;
			push_span(dism_pkg::KIND_LEFT, span_lo[pos-1], val, 1'b1);
		end else if (touch_r) begin
			span_lo[pos] = val;
			push_span(dism_pkg::KIND_RIGHT, val, span_hi[pos], 1'b1);
		end else if (span_cnt >= dism_pkg::CAPACITY) begin
			push_span(dism_pkg::KIND_FULL, val, val, 1'b1);
		end else begin
			for (int i = span_cnt; i > pos; i--) begin
				span_lo[i] = span_lo[i-1];
				span_hi[i] = span_hi[i-1];
			end
			span_lo[pos] = val;
			span_hi[pos] = val;
			span_cnt++;
			push_span(dism_pkg::KIND_NEW, val, val, 1'b1);
		end
	endfunction

	function automatic void expand_list();
		if (span_cnt == 0)
			push_span(dism_pkg::KIND_EMPTY, '0, '0, 1'b1);
		else
			for (int i = 0; i < span_cnt; i++)
				push_span(dism_pkg::KIND_ENTRY, span_lo[i], span_hi[i], i == span_cnt - 1);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_cnt++;
		end
	endfunction

	// Check the result first, then predict: a result never belongs to a request
	// accepted at the same edge.
	always @(posedge clk) begin
		span_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_spans.size() == 0) begin
				$error("unexpected result: kind %0d range %0d..%0d count %0d last %0d",
					rsp.kind, rsp.range_start, rsp.range_end, rsp.entry_count, rsp.last);
				fail_cnt++;
			end else begin
				want = pending_spans.pop_front();
				check_field("kind", 32'(want.kind), 32'(rsp.kind));
				check_field("range_start", 32'(want.lo), 32'(rsp.range_start));
				check_field("range_end", 32'(want.hi), 32'(rsp.range_end));
				check_field("entry_count", 32'(want.count), 32'(rsp.entry_count));
				check_field("last", 32'(want.last), 32'(rsp.last));
			end
		end
		if (arst_n && req.valid && req.ready) begin
			if (req.action == ACT_LIST)
				expand_list();
			else
				apply_add(req.value);
		end
	end

	// Result receiver: random stalls, plus long holds counted here on request.
	initial begin
		int hold_left;
		hold_left = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else if (!rx_stall_en) begin
				rsp.ready <= 1'b1;
			end else if ($urandom_range(0, 59) == 0) begin
				hold_left = $urandom_range(8, 40);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	function automatic int pick_gap();
		if (!tx_gap_en)
			return 0;
		case ($urandom_range(0, 19))
			0:                   return $urandom_range(8, 30);
			1, 2, 3, 4, 5, 6, 7: return $urandom_range(1, 3);
			default:             return 0;
		endcase
	endfunction

	// Aim most adds at the edges and gaps of held intervals so merges keep happening.
	function automatic logic [dism_pkg::DATA_W-1:0] pick_add_value();
		int r;
		int k;
		r = $urandom_range(0, 99);
		if (span_cnt == 0 || r < 25) begin
			case ($urandom_range(0, 5))
				0:       return '0;
				1:       return '1;
				default: return dism_pkg::DATA_W'($urandom);
			endcase
		end
		k = $urandom_range(0, span_cnt - 1);
		if (r < 50)
			return span_hi[k] + 1'b1;
		if (r < 70)
			return span_lo[k] - 1'b1;
		if (r < 85)
			return span_lo[k] +
				dism_pkg::DATA_W'($urandom_range(0, int'(span_hi[k] - span_lo[k])));
		if (k + 1 < span_cnt)
			return span_hi[k] +
				dism_pkg::DATA_W'((int'(span_lo[k+1]) - int'(span_hi[k])) / 2);
		return span_hi[k] + dism_pkg::DATA_W'($urandom_range(1, 3));
	endfunction

	task automatic send_item(input logic act, input logic [dism_pkg::DATA_W-1:0] val,
		input int gap);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid  <= 1'b1;
		req.action <= act;
		req.value  <= val;
		do @(posedge clk); while (req.ready !== 1'b1);
	endtask

	// Drop valid and wait until every predicted result has been seen.
	task automatic drain_results();
		req.valid <= 1'b0;
		do @(negedge clk); while (pending_spans.size() != 0);
		@(posedge clk);
	endtask

	task automatic test_edges();
		send_item(ACT_LIST, 16'h0000, 0);
		send_item(ACT_ADD, 16'hFFFF, 0);
		send_item(ACT_ADD, 16'h0000, 0);
		send_item(ACT_ADD, 16'h0001, 0);
		send_item(ACT_ADD, 16'hFFFE, 0);
		send_item(ACT_ADD, 16'h0003, 0);
		send_item(ACT_ADD, 16'h0002, 0);
		send_item(ACT_ADD, 16'h0002, 0);
		send_item(ACT_LIST, 16'hFFFF, 0);
		drain_results();
	endtask

	// Fill the table, drop on full, merge while full, then refill and drop again.
	task automatic test_full_table();
		send_item(ACT_ADD, 16'd10, 0);
		send_item(ACT_ADD, 16'd12, 0);
		for (int v = 20; v <= 140; v += 10)
			send_item(ACT_ADD, dism_pkg::DATA_W'(v), 0);
		send_item(ACT_ADD, 16'd50000, 0);
		send_item(ACT_ADD, 16'd60000, 0);
		send_item(ACT_ADD, 16'd11, 0);
		send_item(ACT_ADD, 16'd50000, 0);
		send_item(ACT_ADD, 16'd21, 0);
		send_item(ACT_ADD, 16'd19, 0);
		send_item(ACT_ADD, 16'd60000, 0);
		send_item(ACT_ADD, 16'd141, 0);
		send_item(ACT_ADD, 16'd65000, 0);
		send_item(ACT_LIST, 16'h5A5A, 0);
		drain_results();
	endtask

	task automatic test_random_traffic();
		for (int i = 0; i < 240; i++) begin
			if (i == 60) begin
				tx_gap_en   = 1'b1;
				rx_stall_en = 1'b1;
			end
			if (i % 90 == 89)
				drain_results();
			if ($urandom_range(0, 9) == 0)
				send_item(ACT_LIST, dism_pkg::DATA_W'($urandom), pick_gap());
			else
				send_item(ACT_ADD, pick_add_value(), pick_gap());
		end
		drain_results();
	endtask

	// Hold the result side for a long stretch while requests keep coming back to back.
	task automatic test_backpressure();
		hold_request = 200;
		for (int i = 0; i < 14; i++) begin
			if (i % 5 == 4)
				send_item(ACT_LIST, dism_pkg::DATA_W'($urandom), 0);
			else
				send_item(ACT_ADD, pick_add_value(), 0);
		end
		drain_results();
	endtask

	initial begin
		arst_n     <= 1'b0;
		req.valid  <= 1'b0;
		req.action <= ACT_ADD;
		req.value  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_edges();
		test_full_table();
		test_random_traffic();
		test_backpressure();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && pending_spans.size() == 0)
			$display("disjoint_interval_set_merge_core test passed");
		else
			$display("disjoint_interval_set_merge_core test failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("disjoint_interval_set_merge_core test failed");
		$finish;
	end

endmodule
`default_nettype wire
